// File: rtl/salc_pkg.sv
// ----------------------------------------------------------------------------
// salc_pkg
// Shared types and constants of the set-associative LRU cache tag model.
// ----------------------------------------------------------------------------
package salc_pkg;

	localparam int MAX_SETS     = 64;
	localparam int MAX_WAYS     = 8;
	localparam int SET_W        = 6;
	localparam int WAY_W        = 3;
	localparam int AGE_W        = 3;
	localparam int TAG_W        = 62;
	localparam int ADDR_W       = 64;
	localparam int CNT_W        = 32;
	localparam int WAYS_CFG_W   = 4;
	localparam int SETB_CFG_W   = 3;
	localparam int BLKB_CFG_W   = 5;
	localparam int CFG_DATA_W   = 5;
	localparam int CFG_IDX_W    = 2;

	localparam logic [AGE_W-1:0]      AGE_MAX        = '1;
	localparam logic [SETB_CFG_W-1:0] SET_BITS_MAX   = SETB_CFG_W'(SET_W);
	localparam logic [WAYS_CFG_W-1:0] WAYS_MAX       = WAYS_CFG_W'(MAX_WAYS);
	localparam logic [CNT_W-1:0]      CNT_MAX        = '1;

	localparam logic [SETB_CFG_W-1:0] SET_BITS_RST   = 3'd4;
	localparam logic [WAYS_CFG_W-1:0] WAYS_RST       = 4'd1;
	localparam logic [BLKB_CFG_W-1:0] BLOCK_BITS_RST = 5'd4;

	localparam logic [CFG_IDX_W-1:0] REG_SET_BITS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WAYS       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BITS = 2'd2;

	typedef enum logic [1:0] {
		KIND_FETCH  = 2'd0,
		KIND_LOAD   = 2'd1,
		KIND_STORE  = 2'd2,
		KIND_MODIFY = 2'd3
	} kind_t;

	typedef struct packed {
		logic [MAX_WAYS-1:0]             valid;
		logic [MAX_WAYS-1:0][AGE_W-1:0]  age;
		logic [MAX_WAYS-1:0][TAG_W-1:0]  tag;
	} row_t;

	typedef struct packed {
		logic             hit;
		logic             evicted;
		logic [WAY_W-1:0] way;
	} lookup_res_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		sat_inc = (v == CNT_MAX) ? v : v + 1'b1;
	endfunction

endpackage

// File: rtl/salc_addr_split.sv
// ----------------------------------------------------------------------------
// salc_addr_split
// Splits a byte address into set index and tag by the configured bit counts.
// ----------------------------------------------------------------------------
module salc_addr_split import salc_pkg::*; (
	input  logic [ADDR_W-1:0]     address,
	input  logic [SETB_CFG_W-1:0] set_bits,
	input  logic [BLKB_CFG_W-1:0] block_bits,
	output logic [SET_W-1:0]      set_idx,
	output logic [TAG_W-1:0]      tag
);

	logic [SETB_CFG_W-1:0] sb;
	logic [BLKB_CFG_W-1:0] bb;
	logic [BLKB_CFG_W:0]   sh;
	logic [ADDR_W-1:0]     blk_addr;
	logic [ADDR_W-1:0]     tag_addr;
	logic [SET_W-1:0]      set_mask;

	always_comb begin
		if (set_bits == '0) begin
			sb = SETB_CFG_W'(1);
		end else if (set_bits > SET_BITS_MAX) begin
			sb = SET_BITS_MAX;
		end else begin
			sb = set_bits;
		end
		bb = (block_bits == '0) ? BLKB_CFG_W'(1) : block_bits;
		sh = (BLKB_CFG_W+1)'(sb) + (BLKB_CFG_W+1)'(bb);
		blk_addr = address >> bb;
		tag_addr = address >> sh;
		set_mask = ~(SET_W'({SET_W{1'b1}} << sb));
		set_idx  = blk_addr[SET_W-1:0] & set_mask;
		tag      = tag_addr[TAG_W-1:0];
	end

endmodule

// File: rtl/salc_tag_ram.sv
// ----------------------------------------------------------------------------
// salc_tag_ram
// Row store of tags, ages and valid bits, one row per set, with a valid flag
// per row cleared by reset and a registered read port.
// ----------------------------------------------------------------------------
module salc_tag_ram import salc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  logic [SET_W-1:0] rd_addr,
	output row_t             rd_row,
	input  logic             wr_en,
	input  logic [SET_W-1:0] wr_addr,
	input  row_t             wr_row
);

	row_t                mem [MAX_SETS];
	logic [MAX_SETS-1:0] row_vld_q;
	row_t                rd_q;
	logic                rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_row;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			rd_vld_q  <= 1'b0;
		end else begin
			if (wr_en) begin
				row_vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= row_vld_q[rd_addr];
			end
		end
	end

	always_comb begin
		rd_row       = rd_q;
		rd_row.valid = rd_q.valid & {MAX_WAYS{rd_vld_q}};
	end

endmodule

// File: rtl/salc_lookup.sv
// ----------------------------------------------------------------------------
// salc_lookup
// Tag compare, victim choice and LRU age update for one set row.
// ----------------------------------------------------------------------------
module salc_lookup import salc_pkg::*; (
	input  row_t                  cur_row,
	input  logic [TAG_W-1:0]      tag,
	input  logic [WAYS_CFG_W-1:0] ways_in_use,
	output row_t                  nxt_row,
	output lookup_res_t           res
);

	logic [WAYS_CFG_W-1:0] ways_c;
	logic [MAX_WAYS-1:0]   act;
	logic                  found;
	logic                  have_inv;
	logic [WAY_W-1:0]      w;
	logic [WAY_W-1:0]      best;
	logic [AGE_W-1:0]      best_age;
	logic [AGE_W:0]        old_age;

	always_comb begin
		if (ways_in_use == '0) begin
			ways_c = WAYS_CFG_W'(1);
		end else if (ways_in_use > WAYS_MAX) begin
			ways_c = WAYS_MAX;
		end else begin
			ways_c = ways_in_use;
		end
		for (int j = 0; j < MAX_WAYS; j++) begin
			act[j] = (WAYS_CFG_W'(j) < ways_c);
		end

		found = 1'b0;
		w     = '0;
		for (int j = 0; j < MAX_WAYS; j++) begin
			if (!found && act[j] && cur_row.valid[j] && cur_row.tag[j] == tag) begin
				found = 1'b1;
				w     = WAY_W'(j);
			end
		end

		have_inv = 1'b0;
		best     = '0;
		best_age = '0;
		for (int j = 0; j < MAX_WAYS; j++) begin
			if (act[j] && !cur_row.valid[j] && !have_inv) begin
				have_inv = 1'b1;
				if (!found) begin
					w = WAY_W'(j);
				end
			end
			if (act[j] && cur_row.valid[j] && (j == 0 || cur_row.age[j] > best_age)) begin
				best     = WAY_W'(j);
				best_age = cur_row.age[j];
			end
		end
		if (!found && !have_inv) begin
			w = best;
		end

		res.hit     = found;
		res.evicted = !found && !have_inv;
		res.way     = w;

		// true lru: lines younger than the touched one age by one
		old_age = cur_row.valid[w] ? {1'b0, cur_row.age[w]} : {1'b1, {AGE_W{1'b0}}};
		nxt_row = cur_row;
		for (int j = 0; j < MAX_WAYS; j++) begin
			if (act[j] && WAY_W'(j) != w && cur_row.valid[j] &&
			    {1'b0, cur_row.age[j]} < old_age && cur_row.age[j] != AGE_MAX) begin
				nxt_row.age[j] = cur_row.age[j] + 1'b1;
			end
		end
		nxt_row.age[w]   = '0;
		nxt_row.valid[w] = 1'b1;
		if (!found) begin
			nxt_row.tag[w] = tag;
		end
	end

endmodule

// File: rtl/set_assoc_lru_cache_model.sv
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_model
// Tag-only set-associative cache with true LRU replacement and hit, miss and
// eviction totals.
// ----------------------------------------------------------------------------
// A load or store is taken in any cycle in which busy is low and gives one
// result, strobed by done, from the set row read out of the tag store and
// the single lookup-and-write stage behind it, whose outputs are registered;
// one access per cycle is sustained while busy is low. A modify raises busy
// for one cycle and gives two results on consecutive cycles, and no access
// is taken while its busy is high. A fetch is taken and dropped. Results
// cannot be held off: done lasts one cycle. The tag store needs no clearing
// pass after reset; a per-set valid flag covers it. Configuration writes are
// always ready and are meant for idle periods.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_model import salc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [1:0]            kind,
	input  logic [ADDR_W-1:0]     address,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  done,
	output logic                  hit,
	output logic                  evicted,
	output logic [WAY_W-1:0]      way_used,
	output logic                  last,
	output logic [CNT_W-1:0]      hit_total,
	output logic [CNT_W-1:0]      miss_total,
	output logic [CNT_W-1:0]      evict_total
);

	logic [SETB_CFG_W-1:0] set_bits_q;
	logic [WAYS_CFG_W-1:0] ways_q;
	logic [BLKB_CFG_W-1:0] block_bits_q;

	logic             accept;
	logic [SET_W-1:0] set_in;
	logic [TAG_W-1:0] tag_in;

	logic             vld_s1;
	logic             mod_s1;
	logic [SET_W-1:0] set_s1;
	logic [TAG_W-1:0] tag_s1;

	row_t             rd_row;
	row_t             cur_row;
	row_t             nxt_row;
	lookup_res_t      res;

	logic             fwd_vld_q;
	logic [SET_W-1:0] fwd_set_q;
	row_t             fwd_row_q;

	logic             mod2_q;
	logic             done_q;
	logic             hit_q;
	logic             ev_q;
	logic [WAY_W-1:0] way_q;
	logic             last_q;
	logic [CNT_W-1:0] hits_q;
	logic [CNT_W-1:0] miss_q;
	logic [CNT_W-1:0] evict_q;

	assign busy      = vld_s1 && mod_s1;
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q   <= SET_BITS_RST;
			ways_q       <= WAYS_RST;
			block_bits_q <= BLOCK_BITS_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SET_BITS:   set_bits_q   <= cfg_data[SETB_CFG_W-1:0];
				REG_WAYS:       ways_q       <= cfg_data[WAYS_CFG_W-1:0];
				REG_BLOCK_BITS: block_bits_q <= cfg_data[BLKB_CFG_W-1:0];
				default: ;
			endcase
		end
	end

	salc_addr_split u_split (
		.address    (address),
		.set_bits   (set_bits_q),
		.block_bits (block_bits_q),
		.set_idx    (set_in),
		.tag        (tag_in)
	);

	salc_tag_ram u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (set_in),
		.rd_row  (rd_row),
		.wr_en   (vld_s1),
		.wr_addr (set_s1),
		.wr_row  (nxt_row)
	);

	// row written on the previous edge is not yet in the read data
	assign cur_row = (fwd_vld_q && fwd_set_q == set_s1) ? fwd_row_q : rd_row;

	salc_lookup u_lookup (
		.cur_row     (cur_row),
		.tag         (tag_s1),
		.ways_in_use (ways_q),
		.nxt_row     (nxt_row),
		.res         (res)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			mod_s1 <= (kind == KIND_MODIFY);
			set_s1 <= set_in;
			tag_s1 <= tag_in;
		end
		fwd_set_q <= set_s1;
		fwd_row_q <= nxt_row;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			fwd_vld_q <= 1'b0;
			mod2_q    <= 1'b0;
		end else begin
			vld_s1    <= accept && (kind != KIND_FETCH);
			fwd_vld_q <= vld_s1;
			mod2_q    <= vld_s1 && mod_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			hit_q  <= res.hit;
			ev_q   <= res.evicted;
			way_q  <= res.way;
			last_q <= !mod_s1;
		end else if (mod2_q) begin
			// second lookup of a modify always hits the line just touched
			hit_q  <= 1'b1;
			ev_q   <= 1'b0;
			last_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q  <= 1'b0;
			hits_q  <= '0;
			miss_q  <= '0;
			evict_q <= '0;
		end else begin
			done_q <= vld_s1 || mod2_q;
			if (vld_s1) begin
				if (res.hit) begin
					hits_q <= sat_inc(hits_q);
				end else begin
					miss_q <= sat_inc(miss_q);
				end
				if (res.evicted) begin
					evict_q <= sat_inc(evict_q);
				end
			end else if (mod2_q) begin
				hits_q <= sat_inc(hits_q);
			end
		end
	end

	assign done        = done_q;
	assign hit         = hit_q;
	assign evicted     = ev_q;
	assign way_used    = way_q;
	assign last        = last_q;
	assign hit_total   = hits_q;
	assign miss_total  = miss_q;
	assign evict_total = evict_q;

`ifndef SYNTHESIS
	a_lookup_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |=> done_q)
		else $error("lookup without result strobe");

	a_modify_second_result: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && !last_q) |=> (done_q && hit_q && last_q && !ev_q))
		else $error("modify second result missing or wrong");

	a_hits_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) |-> (hits_q >= $past(hits_q)))
		else $error("hit total went down");
`endif

endmodule

// File: test/tb_set_assoc_lru_cache_model.sv
// ----------------------------------------------------------------------------
// tb_set_assoc_lru_cache_model
// Self-checking bench for the LRU cache tag model: a clocked driver feeds
// accesses and register writes from a request queue, a clocked monitor keeps
// its own copy of the tag store and LRU ages, predicts every lookup result
// and compares each strobed result field by field in order.
// ----------------------------------------------------------------------------
module tb_set_assoc_lru_cache_model;
	import salc_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE      = 4;
	localparam int END_SETTLE  = 8;
	localparam int PRINT_CAP   = 40;

	typedef enum logic [1:0] {
		ACT_ACCESS,
		ACT_CONFIG,
		ACT_DRAIN
	} action_t;

	typedef struct {
		action_t                action;
		kind_t                  kind;
		logic [ADDR_W-1:0]      address;
		logic [CFG_IDX_W-1:0]   reg_index;
		logic [CFG_DATA_W-1:0]  reg_data;
		int                     gap;
	} request_t;

	typedef struct {
		logic             hit;
		logic             evicted;
		logic [WAY_W-1:0] way;
		logic             last;
		logic [CNT_W-1:0] hit_total;
		logic [CNT_W-1:0] miss_total;
		logic [CNT_W-1:0] evict_total;
	} lookup_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	kind_t                 kind = KIND_FETCH;
	logic [ADDR_W-1:0]     address = '0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_SET_BITS;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  done;
	logic                  hit;
	logic                  evicted;
	logic [WAY_W-1:0]      way_used;
	logic                  last;
	logic [CNT_W-1:0]      hit_total;
	logic [CNT_W-1:0]      miss_total;
	logic [CNT_W-1:0]      evict_total;

	request_t request_queue[$];
	lookup_t  expected_lookups[$];
	int       wait_count = 0;
	int       idle_cycles = 0;
	int       cycle_count = 0;
	int       error_count = 0;

	// shadow of the tag store, index = set * MAX_WAYS + way
	bit                  tag_valid [MAX_SETS*MAX_WAYS];
	bit [TAG_W-1:0]      tag_store [MAX_SETS*MAX_WAYS];
	bit [AGE_W-1:0]      tag_age   [MAX_SETS*MAX_WAYS];
	bit [CNT_W-1:0]      hits = '0;
	bit [CNT_W-1:0]      misses = '0;
	bit [CNT_W-1:0]      evictions = '0;
	bit [SETB_CFG_W-1:0] cfg_set_bits = SET_BITS_RST;
	bit [WAYS_CFG_W-1:0] cfg_ways = WAYS_RST;
	bit [BLKB_CFG_W-1:0] cfg_block_bits = BLOCK_BITS_RST;

	set_assoc_lru_cache_model DUT (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int eff_set_bits(input logic [SETB_CFG_W-1:0] raw);
		if (raw == 0) return 1;
		if (raw > SET_W) return SET_W;
		return int'(raw);
	endfunction

	function automatic int eff_block_bits(input logic [BLKB_CFG_W-1:0] raw);
		return (raw == 0) ? 1 : int'(raw);
	endfunction

	function automatic logic [CNT_W-1:0] count_up(input logic [CNT_W-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		if (error_count < PRINT_CAP) begin
			$display("mismatch %s: got %0h want %0h (cycle %0d)", what, got, want,
				cycle_count);
		end
		error_count++;
	endtask

	task automatic predict_lookup(input logic [ADDR_W-1:0] addr, input logic is_last);
		int sb, bb, ways, base, w, old, j;
		logic [ADDR_W-1:0] set_idx;
		logic [TAG_W-1:0] tag;
		bit found, have_free;
		lookup_t r;
		sb = eff_set_bits(cfg_set_bits);
		bb = eff_block_bits(cfg_block_bits);
		ways = (cfg_ways == 0) ? 1 : ((cfg_ways > MAX_WAYS) ? MAX_WAYS : int'(cfg_ways));
		set_idx = (addr >> bb) & ((64'd1 << sb) - 1);
		tag = TAG_W'(addr >> (sb + bb));
		base = int'(set_idx) * MAX_WAYS;
		found = 1'b0;
		w = 0;
		for (j = 0; j < ways; j++) begin
			if (!found && tag_valid[base+j] && tag_store[base+j] == tag) begin
				found = 1'b1;
				w = j;
			end
		end
		r = '{default: '0};
		if (found) begin
			r.hit = 1'b1;
			hits = count_up(hits);
		end else begin
			misses = count_up(misses);
			have_free = 1'b0;
			for (j = 0; j < ways; j++) begin
				if (!have_free && !tag_valid[base+j]) begin
					have_free = 1'b1;
					w = j;
				end
			end
			if (!have_free) begin
				// oldest line, lowest way on a tie
				w = 0;
				for (j = 1; j < ways; j++) begin
					if (tag_age[base+j] > tag_age[base+w]) w = j;
				end
				r.evicted = 1'b1;
				evictions = count_up(evictions);
			end
			tag_store[base+w] = tag;
		end
		old = tag_valid[base+w] ? int'(tag_age[base+w]) : int'(AGE_MAX) + 1;
		for (j = 0; j < ways; j++) begin
			if (j != w && tag_valid[base+j] && tag_age[base+j] < old &&
					tag_age[base+j] < AGE_MAX) begin
				tag_age[base+j] = tag_age[base+j] + 1'b1;
			end
		end
		tag_age[base+w] = '0;
		tag_valid[base+w] = 1'b1;
		r.way = w[WAY_W-1:0];
		r.last = is_last;
		r.hit_total = hits;
		r.miss_total = misses;
		r.evict_total = evictions;
		expected_lookups.push_back(r);
	endtask

	task automatic add_access(input kind_t k, input logic [ADDR_W-1:0] a, input int gap);
		request_t q;
		q = '{action: ACT_ACCESS, kind: k, address: a, reg_index: REG_SET_BITS,
			reg_data: '0, gap: gap};
		request_queue.push_back(q);
	endtask

	task automatic add_config(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		request_t q;
		q = '{action: ACT_CONFIG, kind: KIND_FETCH, address: '0, reg_index: idx,
			reg_data: data, gap: 0};
		request_queue.push_back(q);
	endtask

	task automatic add_drain();
		request_t q;
		q = '{action: ACT_DRAIN, kind: KIND_FETCH, address: '0, reg_index: REG_SET_BITS,
			reg_data: '0, gap: 0};
		request_queue.push_back(q);
	endtask

	task automatic run_phase(input int n_lookups, input logic [SETB_CFG_W-1:0] sb_raw,
			input logic [WAYS_CFG_W-1:0] ways_raw, input logic [BLKB_CFG_W-1:0] bb_raw);
		logic [ADDR_W-1:0] tags [10];
		logic [ADDR_W-1:0] a, s, off;
		int sb, bb, made, drain_at, set_span, gap;
		bit no_idle, drained;
		kind_t k;
		add_config(REG_SET_BITS, CFG_DATA_W'(sb_raw));
		add_config(REG_WAYS, CFG_DATA_W'(ways_raw));
		add_config(REG_BLOCK_BITS, bb_raw);
		sb = eff_set_bits(sb_raw);
		bb = eff_block_bits(bb_raw);
		foreach (tags[i]) tags[i] = {$urandom, $urandom};
		set_span = $urandom_range(0, 3);
		no_idle = ($urandom_range(0, 2) == 0);
		drain_at = $urandom_range(1, n_lookups - 1);
		drained = 1'b0;
		made = 0;
		while (made < n_lookups) begin
			if (!drained && made == drain_at) begin
				add_drain();
				drained = 1'b1;
			end
			k = kind_t'($urandom_range(0, 3));
			if ($urandom_range(0, 4) == 0) begin
				a = {$urandom, $urandom};
			end else begin
				// few tags over few sets so that hits and evictions are common
				s = ADDR_W'($urandom_range(0, set_span));
				off = {$urandom, $urandom};
				a = (tags[$urandom_range(0, 9)] << (sb + bb)) |
					((s & ((64'd1 << sb) - 1)) << bb) | (off & ((64'd1 << bb) - 1));
			end
			gap = (no_idle || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
			add_access(k, a, gap);
			made++;
		end
	endtask

	// driver
	always @(posedge clk) begin
		logic free, next_start, next_cfg_valid;
		free = 1'b1;
		next_start = start;
		next_cfg_valid = cfg_valid;
		if (arst_n) begin
			if (start) begin
				if (busy) free = 1'b0;
				else next_start = 1'b0;
			end
			if (cfg_valid) begin
				if (cfg_ready) next_cfg_valid = 1'b0;
				else free = 1'b0;
			end
			if (free && request_queue.size() > 0) begin
				if (wait_count < request_queue[0].gap) begin
					wait_count <= wait_count + 1;
				end else begin
					case (request_queue[0].action)
						ACT_ACCESS: begin
							next_start = 1'b1;
							kind <= request_queue[0].kind;
							address <= request_queue[0].address;
							void'(request_queue.pop_front());
							wait_count <= 0;
						end
						ACT_CONFIG: begin
							if (idle_cycles >= SETTLE && !start) begin
								next_cfg_valid = 1'b1;
								cfg_index <= request_queue[0].reg_index;
								cfg_data <= request_queue[0].reg_data;
								void'(request_queue.pop_front());
								wait_count <= 0;
							end
						end
						default: begin
							// hold off until every result is in
							if (idle_cycles >= SETTLE && !start) begin
								void'(request_queue.pop_front());
								wait_count <= 0;
							end
						end
					endcase
				end
			end
		end
		start <= next_start;
		cfg_valid <= next_cfg_valid;
	end

	// monitor and predictor
	always @(posedge clk) begin
		lookup_t want;
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else if (arst_n) begin
			if (done) begin
				if (expected_lookups.size() == 0) begin
					report_mismatch("result with nothing expected", 64'd1, 64'd0);
				end else begin
					want = expected_lookups.pop_front();
					if (hit !== want.hit) report_mismatch("hit", 64'(hit), 64'(want.hit));
					if (evicted !== want.evicted)
						report_mismatch("evicted", 64'(evicted), 64'(want.evicted));
					if (way_used !== want.way)
						report_mismatch("way_used", 64'(way_used), 64'(want.way));
					if (last !== want.last) report_mismatch("last", 64'(last), 64'(want.last));
					if (hit_total !== want.hit_total)
						report_mismatch("hit_total", 64'(hit_total), 64'(want.hit_total));
					if (miss_total !== want.miss_total)
						report_mismatch("miss_total", 64'(miss_total), 64'(want.miss_total));
					if (evict_total !== want.evict_total)
						report_mismatch("evict_total", 64'(evict_total),
							64'(want.evict_total));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_SET_BITS: cfg_set_bits = cfg_data[SETB_CFG_W-1:0];
					REG_WAYS: cfg_ways = cfg_data[WAYS_CFG_W-1:0];
					REG_BLOCK_BITS: cfg_block_bits = cfg_data[BLKB_CFG_W-1:0];
					default: ;
				endcase
			end
			if (start && !busy) begin
				case (kind)
					KIND_LOAD, KIND_STORE: predict_lookup(address, 1'b1);
					KIND_MODIFY: begin
						predict_lookup(address, 1'b0);
						predict_lookup(address, 1'b1);
					end
					default: ;
				endcase
			end
			if (expected_lookups.size() == 0 && !start && !done && !cfg_valid)
				idle_cycles <= (idle_cycles < 1000) ? idle_cycles + 1 : idle_cycles;
			else
				idle_cycles <= 0;
		end
	end

	initial begin
		// directed part, reset settings: 16 sets, one way, 16-byte blocks
		add_access(KIND_FETCH, '1, 0);
		add_access(KIND_LOAD, '0, 0);
		add_access(KIND_STORE, 64'h0000_0000_0000_000F, 0);
		add_access(KIND_MODIFY, '1, 3);
		add_access(KIND_LOAD, 64'h0000_0000_0000_0100, 0);
		add_access(KIND_STORE, '0, 1);
		add_access(KIND_MODIFY, 64'h5555_5555_5555_5555, 0);
		add_access(KIND_MODIFY, 64'hAAAA_AAAA_AAAA_AAAA, 0);
		add_access(KIND_FETCH, '0, 0);
		add_access(KIND_LOAD, 64'h8000_0000_0000_0000, 2);
		add_drain();
		// lru order within set 0, then ways switched off and back on
		add_config(REG_WAYS, 5'd3);
		add_access(KIND_LOAD, 64'h0000_0000_0000_0100, 0);
		add_access(KIND_LOAD, 64'h0000_0000_0000_0200, 0);
		add_access(KIND_LOAD, 64'h0000_0000_0000_0100, 0);
		add_access(KIND_STORE, 64'h0000_0000_0000_0300, 0);
		add_access(KIND_LOAD, 64'h0000_0000_0000_0200, 0);
		add_config(REG_WAYS, 5'd2);
		add_access(KIND_MODIFY, 64'h0000_0000_0000_0400, 0);
		add_config(REG_WAYS, 5'd3);
		add_access(KIND_LOAD, 64'h0000_0000_0000_0200, 0);
		add_access(KIND_LOAD, 64'h0000_0000_0000_0500, 0);

		run_phase(90, 3'd1, 4'd2, 5'd1);
		run_phase(90, 3'd6, 4'd8, 5'd16);
		run_phase(90, 3'd0, 4'd0, 5'd0);
		run_phase(90, 3'd7, 4'd15, 5'd31);
		run_phase(90, 3'd2, 4'd4, 5'd5);
		run_phase(90, 3'd2, 4'd2, 5'd5);
		run_phase(90, 3'd2, 4'd8, 5'd5);
		repeat (3) begin
			run_phase(90, SETB_CFG_W'($urandom_range(0, 7)),
				WAYS_CFG_W'($urandom_range(0, 15)), BLKB_CFG_W'($urandom_range(0, 31)));
		end

		repeat (6) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		do @(negedge clk);
		while (request_queue.size() != 0 || start || cfg_valid || idle_cycles < END_SETTLE);
		if (error_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
